/* hw/rtl/fpr_pkg.sv */
// Shared types and constants for the framed packet receiver.
package fpr_pkg;

    // Payload buffer depth and derived widths
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int COUNT_W     = 7;

    // Configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  START_FIRST_RST  = 8'd170;
    localparam logic [7:0]  START_SECOND_RST = 8'd85;
    localparam logic [15:0] TIMEOUT_RST      = 16'd10000;

    // Command codes of the input item
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PAYLOAD  = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    // Report request from the deframer to the replay unit
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] id;
        logic [7:0] length;
    } job_t;

endpackage

/* hw/rtl/fpr_if.sv */
// Handshake channel interfaces: received items, results and configuration writes.
interface fpr_byte_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink (input valid, command, rx_byte, output ready);
endinterface

interface fpr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;

    modport source (output valid, status, frame_id, frame_length, byte_index,
                    payload_byte, last, input ready);
    modport sink (input valid, status, frame_id, frame_length, byte_index,
                  payload_byte, last, output ready);
endinterface

interface fpr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fpr_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [fpr_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* hw/rtl/fpr_payload_ram.sv */
// Simple dual-port payload buffer: one write port, one registered read port.
module fpr_payload_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/fpr_deframer.sv */
// Frame parser: start hunt, header, payload buffering, checksum and timeout.
module fpr_deframer (
    input  logic                        clk,
    input  logic                        rst_n,
    fpr_byte_if.sink                    byte_chan,
    fpr_cfg_if.sink                     cfg_chan,
    input  logic                        rp_busy,
    input  logic                        job_take,
    output fpr_pkg::job_t               job,
    output logic                        wr_en,
    output logic [fpr_pkg::ADDR_W-1:0]  wr_addr,
    output logic [7:0]                  wr_data
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [7:0]                    previous_byte_reg, previous_byte_next;
    logic [7:0]                    held_id_reg, held_id_next;
    logic [7:0]                    held_length_reg, held_length_next;
    logic [fpr_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]                    running_sum_reg, running_sum_next;
    logic [15:0]                   elapsed_reg, elapsed_next;
    fpr_pkg::job_t                 job_reg, job_next;

    logic [7:0]                    start_first_reg;
    logic [7:0]                    start_second_reg;
    logic [15:0]                   timeout_reg;

    logic                          accept;
    logic                          do_hunt;
    logic [7:0]                    b;
    logic [fpr_pkg::COUNT_W-1:0]   count_inc;

    // Take a new item only once the previous report has fully drained
    assign byte_chan.ready = !job_reg.valid && !rp_busy;
    assign accept          = byte_chan.valid && byte_chan.ready;
    assign b               = byte_chan.rx_byte;
    assign count_inc       = count_reg + 1'b1;
    assign cfg_chan.ready  = 1'b1;

    assign job     = job_reg;
    assign wr_addr = count_reg[fpr_pkg::ADDR_W-1:0];
    assign wr_data = b;

    // Next-state logic for the frame parser
    always_comb
    begin
        phase_next         = phase_reg;
        previous_byte_next = previous_byte_reg;
        held_id_next       = held_id_reg;
        held_length_next   = held_length_reg;
        count_next         = count_reg;
        running_sum_next   = running_sum_reg;
        elapsed_next       = elapsed_reg;
        job_next           = job_reg;
        wr_en              = 1'b0;
        do_hunt            = 1'b0;

        if (job_reg.valid && job_take)
        begin
            job_next.valid = 1'b0;
        end

        if (accept)
        begin
            if (byte_chan.command == fpr_pkg::CMD_TICK)
            begin
                if (phase_reg != PH_HUNT && elapsed_reg != 16'hFFFF)
                begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end
            else if (phase_reg == PH_HUNT)
            begin
                do_hunt = 1'b1;
            end
            else if (elapsed_reg >= timeout_reg)
            begin
                // Drop the frame and feed this byte to the hunt
                job_next = '{valid: 1'b1, status: fpr_pkg::ST_TIMEOUT,
                             id: held_id_reg, length: held_length_reg};
                phase_next = PH_HUNT;
                do_hunt    = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_ID:
                    begin
                        held_id_next     = b;
                        running_sum_next = b;
                        phase_next       = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        held_length_next = b;
                        running_sum_next = running_sum_reg + b;
                        count_next       = '0;
                        if (b > 8'(fpr_pkg::MAX_PAYLOAD))
                        begin
                            job_next = '{valid: 1'b1, status: fpr_pkg::ST_TOO_LONG,
                                         id: held_id_reg, length: b};
                            phase_next = PH_HUNT;
                        end
                        else if (b == 8'd0)
                        begin
                            phase_next = PH_SUM;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        wr_en            = 1'b1;
                        count_next       = count_inc;
                        running_sum_next = running_sum_reg + b;
                        if ({1'b0, count_inc} >= held_length_reg)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        phase_next         = PH_HUNT;
                        job_next.valid     = 1'b1;
                        job_next.id        = held_id_reg;
                        job_next.length    = held_length_reg;
                        if (b != running_sum_reg)
                        begin
                            job_next.status = fpr_pkg::ST_BAD_SUM;
                        end
                        else if (held_length_reg == 8'd0)
                        begin
                            job_next.status = fpr_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            job_next.status = fpr_pkg::ST_PAYLOAD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                        do_hunt    = 1'b1;
                    end
                endcase
            end

            // Look for the two-byte start pattern
            if (do_hunt)
            begin
                if (previous_byte_reg == start_first_reg && b == start_second_reg)
                begin
                    phase_next         = PH_ID;
                    previous_byte_next = '0;
                    held_id_next       = '0;
                    held_length_next   = '0;
                    count_next         = '0;
                    running_sum_next   = '0;
                    elapsed_next       = '0;
                end
                else
                begin
                    previous_byte_next = b;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            previous_byte_reg <= '0;
            held_id_reg       <= '0;
            held_length_reg   <= '0;
            count_reg         <= '0;
            running_sum_reg   <= '0;
            elapsed_reg       <= '0;
            job_reg           <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            previous_byte_reg <= previous_byte_next;
            held_id_reg       <= held_id_next;
            held_length_reg   <= held_length_next;
            count_reg         <= count_next;
            running_sum_reg   <= running_sum_next;
            elapsed_reg       <= elapsed_next;
            job_reg           <= job_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= fpr_pkg::START_FIRST_RST;
            start_second_reg <= fpr_pkg::START_SECOND_RST;
            timeout_reg      <= fpr_pkg::TIMEOUT_RST;
        end
        else if (cfg_chan.valid && cfg_chan.ready)
        begin
            case (cfg_chan.reg_index)
                fpr_pkg::CFG_START_FIRST:  start_first_reg  <= cfg_chan.wr_data[7:0];
                fpr_pkg::CFG_START_SECOND: start_second_reg <= cfg_chan.wr_data[7:0];
                fpr_pkg::CFG_TIMEOUT:      timeout_reg      <= cfg_chan.wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Buffer writes stay inside the payload area
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(count_reg) < fpr_pkg::MAX_PAYLOAD))
        else $error("payload write beyond buffer");

    // Payload phase only with a legal nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |->
            (held_length_reg != 8'd0 && held_length_reg <= 8'(fpr_pkg::MAX_PAYLOAD)))
        else $error("payload phase with illegal length");

    // A found start pattern restarts timing and counting
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ID && $past(phase_reg) == PH_HUNT) |->
            (elapsed_reg == 16'd0 && count_reg == '0 && running_sum_reg == 8'd0))
        else $error("frame state not cleared at start");

endmodule

/* hw/rtl/fpr_replay.sv */
// Result sequencer: reads the payload buffer and drives the result register.
module fpr_replay (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpr_pkg::job_t               job,
    output logic                        job_take,
    output logic                        rp_busy,
    output logic                        rd_en,
    output logic [fpr_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [7:0]                  rd_data,
    fpr_result_if.source                result_chan
);

    typedef enum logic [1:0] {
        RP_IDLE,
        RP_ISSUE,
        RP_CAPTURE,
        RP_SEND
    } rp_state_t;

    rp_state_t        state_reg;
    fpr_pkg::status_t status_reg;
    logic [7:0]       id_reg;
    logic [7:0]       len_reg;
    logic [5:0]       idx_reg;
    logic [7:0]       data_reg;
    logic             last_reg;

    assign job_take = (state_reg == RP_IDLE);
    assign rp_busy  = (state_reg != RP_IDLE);
    assign rd_en    = (state_reg == RP_ISSUE);
    assign rd_addr  = idx_reg[fpr_pkg::ADDR_W-1:0];

    assign result_chan.valid        = (state_reg == RP_SEND);
    assign result_chan.status       = status_reg;
    assign result_chan.frame_id     = id_reg;
    assign result_chan.frame_length = len_reg;
    assign result_chan.byte_index   = idx_reg;
    assign result_chan.payload_byte = data_reg;
    assign result_chan.last         = last_reg;

    // Sequence reads and hold each result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= RP_IDLE;
            status_reg <= fpr_pkg::ST_PAYLOAD;
            id_reg     <= '0;
            len_reg    <= '0;
            idx_reg    <= '0;
            data_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                RP_IDLE:
                begin
                    if (job.valid)
                    begin
                        status_reg <= job.status;
                        id_reg     <= job.id;
                        len_reg    <= job.length;
                        idx_reg    <= '0;
                        data_reg   <= '0;
                        if (job.status == fpr_pkg::ST_PAYLOAD)
                        begin
                            state_reg <= RP_ISSUE;
                        end
                        else
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= RP_SEND;
                        end
                    end
                end
                RP_ISSUE:
                begin
                    state_reg <= RP_CAPTURE;
                end
                RP_CAPTURE:
                begin
                    data_reg  <= rd_data;
                    last_reg  <= ((8'(idx_reg) + 8'd1) == len_reg);
                    state_reg <= RP_SEND;
                end
                RP_SEND:
                begin
                    if (result_chan.ready)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= RP_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 6'd1;
                            state_reg <= RP_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= RP_IDLE;
                end
            endcase
        end
    end

    // The final item of a report frees the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.ready && result_chan.last) |=>
            (state_reg == RP_IDLE))
        else $error("sequencer busy after final item");

    // Payload positions stay below the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && status_reg == fpr_pkg::ST_PAYLOAD) |->
            ({2'b00, idx_reg} < len_reg))
        else $error("payload index beyond frame length");

    // A waiting item holds still until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && !result_chan.ready) |=>
            (result_chan.valid && $stable(status_reg) && $stable(idx_reg)
             && $stable(data_reg) && $stable(last_reg)))
        else $error("waiting item changed");

endmodule

/* hw/rtl/framed_packet_receiver_unit.sv */
// Timing: a byte that causes a report sets a registered report request; a status result
// is presented by the sequencer without a buffer read, the first payload result after a
// buffer read and capture; each further payload result passes buffer read, capture, present.
// Throughput: one item per cycle while no report is pending; a byte that causes a
// report holds input off until its last result is taken, plus any result-side wait.
// Reset: rst_n clears control state and loads register defaults; buffer is not cleared.
module framed_packet_receiver_unit (
    input  logic          clk,
    input  logic          rst_n,
    fpr_byte_if.sink      byte_chan,
    fpr_result_if.source  result_chan,
    fpr_cfg_if.sink       cfg_chan
);

    fpr_pkg::job_t               job;
    logic                        job_take;
    logic                        rp_busy;
    logic                        wr_en;
    logic [fpr_pkg::ADDR_W-1:0]  wr_addr;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [fpr_pkg::ADDR_W-1:0]  rd_addr;
    logic [7:0]                  rd_data;

    // Parse frames and fill the buffer
    fpr_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .cfg_chan  (cfg_chan),
        .rp_busy   (rp_busy),
        .job_take  (job_take),
        .job       (job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Payload buffer
    fpr_payload_ram #(
        .DEPTH  (fpr_pkg::MAX_PAYLOAD),
        .WIDTH  (8),
        .ADDR_W (fpr_pkg::ADDR_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Emit reports
    fpr_replay u_replay (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_take    (job_take),
        .rp_busy     (rp_busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .result_chan (result_chan)
    );

endmodule
